FILE: src/mips_alu_pkg.sv
`timescale 1ns / 1ps
// Shared types and constants for the MIPS execute-stage ALU.
// No dependencies; imported by the ALU top level and its checker.
package mips_alu_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int FIELD_WIDTH    = 32;
   localparam int OP_WIDTH       = 6;

   typedef enum logic [OP_WIDTH-1:0] {
      OP_ADD   = 6'd0,
      OP_ADDU  = 6'd1,
      OP_SUB   = 6'd2,
      OP_SUBU  = 6'd3,
      OP_MUL   = 6'd4,
      OP_MULU  = 6'd5,
      OP_DIV   = 6'd6,
      OP_DIVU  = 6'd7,
      OP_XOR   = 6'd8,
      OP_NEG   = 6'd9,
      OP_NEGU  = 6'd10,
      OP_REM   = 6'd11,
      OP_REMU  = 6'd12,
      OP_ADDR  = 6'd13,
      OP_STORE = 6'd14,
      OP_SEQ   = 6'd15,
      OP_SGE   = 6'd16,
      OP_SGT   = 6'd17,
      OP_SLE   = 6'd18,
      OP_SLT   = 6'd19,
      OP_SNE   = 6'd20,
      OP_BEQ   = 6'd21,
      OP_BNE   = 6'd22,
      OP_BGE   = 6'd23,
      OP_BLE   = 6'd24,
      OP_BGT   = 6'd25,
      OP_BLT   = 6'd26,
      OP_BEQZ  = 6'd27,
      OP_BNEZ  = 6'd28,
      OP_BGEZ  = 6'd29,
      OP_BLEZ  = 6'd30,
      OP_BGTZ  = 6'd31,
      OP_BLTZ  = 6'd32,
      OP_LINK  = 6'd33,
      OP_MOVE  = 6'd34,
      OP_MFHI  = 6'd35,
      OP_MFLO  = 6'd36,
      OP_NOP   = 6'd37
   } op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MUL,
      ST_DIV,
      ST_DONE
   } state_type;

endpackage

FILE: src/mips_execute_stage_alu_unit.sv
`timescale 1ns / 1ps
// Simple operations are registered: rsp_valid rises in the cycle after acceptance.
// Multiply and divide step through ST_MUL or ST_DIV, one bit per cycle through
// the shared shift-add / restoring-divide shift registers, then ST_DONE.
// One request per cycle for simple operations while the response is not stalled;
// no new request is taken until a multiply or divide has issued its response.
// Reset (synchronous, active high) clears control state and the hi/lo pair.
module mips_execute_stage_alu_unit #(
   parameter int DATA_WIDTH = mips_alu_pkg::DATA_WIDTH_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 req_valid,
   output logic                                 req_ready,
   input  logic [mips_alu_pkg::OP_WIDTH-1:0]    req_operation,
   input  logic [mips_alu_pkg::FIELD_WIDTH-1:0] req_operand_a,
   input  logic [mips_alu_pkg::FIELD_WIDTH-1:0] req_operand_b,
   input  logic [mips_alu_pkg::FIELD_WIDTH-1:0] req_immediate,
   input  logic [mips_alu_pkg::FIELD_WIDTH-1:0] req_next_pc,
   input  logic                                 req_write_to_register,
   output logic                                 rsp_valid,
   input  logic                                 rsp_ready,
   output logic [mips_alu_pkg::FIELD_WIDTH-1:0] rsp_result,
   output logic [mips_alu_pkg::FIELD_WIDTH-1:0] rsp_target_address,
   output logic                                 rsp_branch_taken,
   output logic                                 rsp_divide_by_zero
);
   import mips_alu_pkg::*;

   localparam int W  = DATA_WIDTH;
   localparam int CW = $clog2(DATA_WIDTH);

   state_type               state_ff, state_in;
   logic [CW-1:0]           count_ff, count_in;
   op_type                  op_ff, op_in;
   logic                    wr_ff, wr_in;
   logic                    sgn_ff, sgn_in;
   logic                    neg_q_ff, neg_q_in;
   logic                    neg_r_ff, neg_r_in;
   logic                    dz_ff, dz_in;
   logic [W:0]              opnd_ff, opnd_in;
   logic [W:0]              acc_ff, acc_in;
   logic [W-1:0]            shreg_ff, shreg_in;
   logic [W-1:0]            hi_ff, hi_in;
   logic [W-1:0]            lo_ff, lo_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [FIELD_WIDTH-1:0]  rsp_result_ff, rsp_result_in;
   logic [FIELD_WIDTH-1:0]  rsp_target_ff, rsp_target_in;
   logic                    rsp_taken_ff, rsp_taken_in;
   logic                    rsp_dz_ff, rsp_dz_in;

   op_type                  req_op;
   logic [W-1:0]            a_w, b_w;
   logic                    a_lt_b, b_lt_a, a_eq_b, a_zero, a_neg;
   logic                    out_free, accept, br_cond;
   logic [W-1:0]            simple_res;
   logic [FIELD_WIDTH-1:0]  simple_tgt;
   logic                    simple_taken;
   logic                    div_na, div_nb;
   logic [W:0]              mul_sum;
   logic                    mul_sub;
   logic [W:0]              rem_sh;
   logic [W+1:0]            div_diff;
   logic [W-1:0]            quot_fix, rem_fix;

   assign req_op   = op_type'(req_operation);
   assign a_w      = W'(req_operand_a);
   assign b_w      = W'(req_operand_b);
   assign a_lt_b   = $signed(a_w) < $signed(b_w);
   assign b_lt_a   = $signed(b_w) < $signed(a_w);
   assign a_eq_b   = a_w == b_w;
   assign a_zero   = a_w == '0;
   assign a_neg    = a_w[W-1];
   assign out_free = !rsp_valid_ff || rsp_ready;
   assign req_ready = (state_ff == ST_IDLE) && out_free;
   assign accept   = req_valid && req_ready;

   assign mul_sub  = sgn_ff && (count_ff == '0) && shreg_ff[0];
   assign mul_sum  = mul_sub ? acc_ff - opnd_ff
                             : acc_ff + (shreg_ff[0] ? opnd_ff : '0);
   assign rem_sh   = {acc_ff[W-1:0], shreg_ff[W-1]};
   assign div_diff = {1'b0, rem_sh} - {2'b00, opnd_ff[W-1:0]};
   assign quot_fix = neg_q_ff ? W'(-shreg_ff) : shreg_ff;
   assign rem_fix  = neg_r_ff ? W'(-acc_ff[W-1:0]) : acc_ff[W-1:0];

   always_comb begin
      simple_res   = '0;
      simple_tgt   = '0;
      simple_taken = 1'b0;
      br_cond      = 1'b0;
      case (req_op)
         OP_ADD, OP_ADDU:   simple_res = a_w + b_w;
         OP_SUB, OP_SUBU:   simple_res = a_w - b_w;
         OP_XOR:            simple_res = a_w ^ b_w;
         OP_NEG, OP_NEGU:   simple_res = W'(-a_w);
         OP_ADDR:           simple_tgt = req_immediate + FIELD_WIDTH'(a_w);
         OP_STORE: begin
            simple_tgt = req_immediate + FIELD_WIDTH'(a_w);
            simple_res = b_w;
         end
         OP_SEQ:            simple_res = W'(a_eq_b);
         OP_SGE:            simple_res = W'(!a_lt_b);
         OP_SGT:            simple_res = W'(b_lt_a);
         OP_SLE:            simple_res = W'(!b_lt_a);
         OP_SLT:            simple_res = W'(a_lt_b);
         OP_SNE:            simple_res = W'(!a_eq_b);
         OP_BEQ:            br_cond = a_eq_b;
         OP_BNE:            br_cond = !a_eq_b;
         OP_BGE:            br_cond = !a_lt_b;
         OP_BLE:            br_cond = !b_lt_a;
         OP_BGT:            br_cond = b_lt_a;
         OP_BLT:            br_cond = a_lt_b;
         OP_BEQZ:           br_cond = a_zero;
         OP_BNEZ:           br_cond = !a_zero;
         OP_BGEZ:           br_cond = !a_neg;
         OP_BLEZ:           br_cond = a_zero || a_neg;
         OP_BGTZ:           br_cond = !a_zero && !a_neg;
         OP_BLTZ:           br_cond = a_neg;
         OP_LINK:           simple_tgt = req_next_pc;
         OP_MOVE:           simple_res = a_w;
         OP_MFHI:           simple_res = hi_ff;
         OP_MFLO:           simple_res = lo_ff;
         default:           simple_res = '0;
      endcase
      if (req_op inside {[OP_BEQ:OP_BLTZ]}) begin
         simple_taken = br_cond;
         simple_tgt   = br_cond ? req_immediate : req_next_pc;
      end
   end

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      op_in         = op_ff;
      wr_in         = wr_ff;
      sgn_in        = sgn_ff;
      neg_q_in      = neg_q_ff;
      neg_r_in      = neg_r_ff;
      dz_in         = dz_ff;
      opnd_in       = opnd_ff;
      acc_in        = acc_ff;
      shreg_in      = shreg_ff;
      hi_in         = hi_ff;
      lo_in         = lo_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_result_in = rsp_result_ff;
      rsp_target_in = rsp_target_ff;
      rsp_taken_in  = rsp_taken_ff;
      rsp_dz_in     = rsp_dz_ff;
      div_na        = (req_op == OP_DIV || req_op == OP_REM) && a_w[W-1];
      div_nb        = (req_op == OP_DIV || req_op == OP_REM) && b_w[W-1];
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               op_in    = req_op;
               wr_in    = req_write_to_register;
               count_in = CW'(W - 1);
               acc_in   = '0;
               if (req_op == OP_MUL || req_op == OP_MULU) begin
                  sgn_in   = req_op == OP_MUL;
                  opnd_in  = {(req_op == OP_MUL) && a_w[W-1], a_w};
                  shreg_in = b_w;
                  state_in = ST_MUL;
               end else if (req_op inside {OP_DIV, OP_DIVU, OP_REM, OP_REMU}) begin
                  sgn_in   = 1'b0;
                  dz_in    = b_w == '0;
                  neg_q_in = (div_na ^ div_nb) && (b_w != '0);
                  neg_r_in = div_na;
                  opnd_in  = {1'b0, div_nb ? W'(-b_w) : b_w};
                  shreg_in = div_na ? W'(-a_w) : a_w;
                  state_in = ST_DIV;
               end else begin
                  rsp_valid_in  = 1'b1;
                  rsp_result_in = FIELD_WIDTH'(simple_res);
                  rsp_target_in = simple_tgt;
                  rsp_taken_in  = simple_taken;
                  rsp_dz_in     = 1'b0;
               end
            end
         end
         ST_MUL: begin
            acc_in   = {sgn_ff && mul_sum[W], mul_sum[W:1]};
            shreg_in = {mul_sum[0], shreg_ff[W-1:1]};
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DIV: begin
            if (!div_diff[W+1]) begin
               acc_in = div_diff[W:0];
            end else begin
               acc_in = rem_sh;
            end
            shreg_in = {shreg_ff[W-2:0], !div_diff[W+1]};
            count_in = count_ff - 1'b1;
            if (count_ff == '0) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_result_in = '0;
               rsp_target_in = '0;
               rsp_taken_in  = 1'b0;
               rsp_dz_in     = 1'b0;
               state_in      = ST_IDLE;
               if (op_ff == OP_MUL || op_ff == OP_MULU) begin
                  if (wr_ff) begin
                     rsp_result_in = FIELD_WIDTH'(shreg_ff);
                  end else begin
                     hi_in = acc_ff[W-1:0];
                     lo_in = shreg_ff;
                  end
               end else if (op_ff == OP_DIV || op_ff == OP_DIVU) begin
                  rsp_dz_in = dz_ff;
                  if (wr_ff) begin
                     rsp_result_in = FIELD_WIDTH'(quot_fix);
                  end else begin
                     hi_in = rem_fix;
                     lo_in = quot_fix;
                  end
               end else begin
                  rsp_dz_in     = dz_ff;
                  rsp_result_in = FIELD_WIDTH'(rem_fix);
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hi_ff        <= '0;
         lo_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hi_ff        <= hi_in;
         lo_ff        <= lo_in;
      end
   end

   always_ff @(posedge clock) begin
      count_ff      <= count_in;
      op_ff         <= op_in;
      wr_ff         <= wr_in;
      sgn_ff        <= sgn_in;
      neg_q_ff      <= neg_q_in;
      neg_r_ff      <= neg_r_in;
      dz_ff         <= dz_in;
      opnd_ff       <= opnd_in;
      acc_ff        <= acc_in;
      shreg_ff      <= shreg_in;
      rsp_result_ff <= rsp_result_in;
      rsp_target_ff <= rsp_target_in;
      rsp_taken_ff  <= rsp_taken_in;
      rsp_dz_ff     <= rsp_dz_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_result         = rsp_result_ff;
   assign rsp_target_address = rsp_target_ff;
   assign rsp_branch_taken   = rsp_taken_ff;
   assign rsp_divide_by_zero = rsp_dz_ff;

endmodule

FILE: src/mips_alu_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the MIPS execute-stage ALU, with its bind.
// Depends on mips_alu_pkg and mips_execute_stage_alu_unit.
module mips_alu_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 req_valid,
   input logic                                 req_ready,
   input logic                                 rsp_valid,
   input logic                                 rsp_ready,
   input logic [mips_alu_pkg::FIELD_WIDTH-1:0] rsp_result,
   input logic [mips_alu_pkg::FIELD_WIDTH-1:0] rsp_target_address,
   input logic                                 rsp_branch_taken,
   input logic                                 rsp_divide_by_zero
);
   import mips_alu_pkg::*;

   a_reset_clears_rsp: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_result)
         && $stable(rsp_target_address))
      else $error("stalled response changed");

   a_no_req_when_blocked: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |-> !req_ready)
      else $error("request taken while response stalled");

   a_taken_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_branch_taken |-> rsp_result == '0 && !rsp_divide_by_zero)
      else $error("taken branch carries data or divide flag");

   a_dz_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_divide_by_zero |-> rsp_target_address == '0 && !rsp_branch_taken)
      else $error("divide flag with address or branch");

endmodule

bind mips_execute_stage_alu_unit mips_alu_checker u_mips_alu_checker (.*);

FILE: bench/testbench.sv
`timescale 1ns / 1ps
// Self-checking bench for mips_execute_stage_alu_unit: directed corner cases,
// then random requests.
// Depends on mips_alu_pkg for the op codes and field widths; holds its own hi/lo copy.
module testbench;
   import mips_alu_pkg::*;

   localparam int IDLE_PCT       = 12;
   localparam int QUIET_START    = 700;
   localparam int QUIET_END      = 1000;
   localparam int RANDOM_ITEMS   = 1700;
   localparam int STALL_LIMIT    = 2000;
   localparam int DRAIN_CYCLES   = 80;
   localparam int MAX_SHOWN      = 10;
   localparam int FIRST_UNKNOWN_OP = int'(OP_NOP) + 1;
   localparam int LAST_OP_CODE   = (1 << OP_WIDTH) - 1;

   typedef logic [FIELD_WIDTH-1:0] word_type;

   typedef struct packed {
      logic [OP_WIDTH-1:0] operation;
      word_type            operand_a;
      word_type            operand_b;
      word_type            immediate;
      word_type            next_pc;
      logic                write_to_register;
   } alu_req_type;

   typedef struct packed {
      word_type result;
      word_type target_address;
      logic     branch_taken;
      logic     divide_by_zero;
   } alu_rsp_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic [OP_WIDTH-1:0] req_operation = '0;
   word_type            req_operand_a = '0;
   word_type            req_operand_b = '0;
   word_type            req_immediate = '0;
   word_type            req_next_pc = '0;
   logic                req_write_to_register = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   word_type            rsp_result;
   word_type            rsp_target_address;
   logic                rsp_branch_taken;
   logic                rsp_divide_by_zero;

   alu_req_type pending_reqs[$];
   alu_rsp_type expected_rsps[$];
   word_type    hi_word;
   word_type    lo_word;
   int          mismatches = 0;
   int          sent_reqs = 0;
   int          accepted_rsps = 0;
   int          quiet_cycles = 0;

   mips_execute_stage_alu_unit dut (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_ready             (req_ready),
      .req_operation         (req_operation),
      .req_operand_a         (req_operand_a),
      .req_operand_b         (req_operand_b),
      .req_immediate         (req_immediate),
      .req_next_pc           (req_next_pc),
      .req_write_to_register (req_write_to_register),
      .rsp_valid             (rsp_valid),
      .rsp_ready             (rsp_ready),
      .rsp_result            (rsp_result),
      .rsp_target_address    (rsp_target_address),
      .rsp_branch_taken      (rsp_branch_taken),
      .rsp_divide_by_zero    (rsp_divide_by_zero)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   function automatic bit take_break(int count);
      return (count < QUIET_START || count >= QUIET_END) &&
             ($urandom_range(0, 99) < IDLE_PCT);
   endfunction

   function automatic word_type pick_operand();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return 32'h0000_0001;
         2: return 32'hffff_ffff;
         3: return 32'h8000_0000;
         4: return 32'h7fff_ffff;
         5: return word_type'($urandom_range(0, 15));
         6: return 32'd0 - word_type'($urandom_range(1, 16));
         default: return word_type'($urandom());
      endcase
   endfunction

   // Execute one request against the local hi/lo copy and return the response it should give.
   function automatic alu_rsp_type predict_execute(alu_req_type r);
      alu_rsp_type o;
      logic [63:0] prod;
      word_type    a, b, quo, rmd, ua, ub, uq, ur;
      logic        zero_div, is_branch, cond;
      a = r.operand_a;
      b = r.operand_b;
      o = '0;
      is_branch = 1'b0;
      cond = 1'b0;
      zero_div = (b == '0);
      if (zero_div) begin
         quo = '1;
         rmd = a;
      end else if (r.operation == OP_DIV || r.operation == OP_REM) begin
         ua = a[31] ? 32'd0 - a : a;
         ub = b[31] ? 32'd0 - b : b;
         uq = ua / ub;
         ur = ua % ub;
         quo = (a[31] != b[31]) ? 32'd0 - uq : uq;
         rmd = a[31] ? 32'd0 - ur : ur;
      end else begin
         quo = a / b;
         rmd = a % b;
      end
      case (r.operation)
         OP_ADD, OP_ADDU: o.result = a + b;
         OP_SUB, OP_SUBU: o.result = a - b;
         OP_MUL, OP_MULU: begin
            if (r.write_to_register) begin
               o.result = a * b;
            end else begin
               if (r.operation == OP_MUL) prod = {{32{a[31]}}, a} * {{32{b[31]}}, b};
               else prod = {32'd0, a} * {32'd0, b};
               hi_word = prod[63:32];
               lo_word = prod[31:0];
            end
         end
         OP_DIV, OP_DIVU: begin
            o.divide_by_zero = zero_div;
            if (r.write_to_register) begin
               o.result = quo;
            end else begin
               lo_word = quo;
               hi_word = rmd;
            end
         end
         OP_XOR: o.result = a ^ b;
         OP_NEG, OP_NEGU: o.result = 32'd0 - a;
         OP_REM, OP_REMU: begin
            o.divide_by_zero = zero_div;
            o.result = rmd;
         end
         OP_ADDR: o.target_address = r.immediate + a;
         OP_STORE: begin
            o.target_address = r.immediate + a;
            o.result = b;
         end
         OP_SEQ: o.result = word_type'(a == b);
         OP_SGE: o.result = word_type'(!($signed(a) < $signed(b)));
         OP_SGT: o.result = word_type'($signed(b) < $signed(a));
         OP_SLE: o.result = word_type'(!($signed(b) < $signed(a)));
         OP_SLT: o.result = word_type'($signed(a) < $signed(b));
         OP_SNE: o.result = word_type'(a != b);
         OP_BEQ: begin is_branch = 1'b1; cond = (a == b); end
         OP_BNE: begin is_branch = 1'b1; cond = (a != b); end
         OP_BGE: begin is_branch = 1'b1; cond = !($signed(a) < $signed(b)); end
         OP_BLE: begin is_branch = 1'b1; cond = !($signed(b) < $signed(a)); end
         OP_BGT: begin is_branch = 1'b1; cond = ($signed(b) < $signed(a)); end
         OP_BLT: begin is_branch = 1'b1; cond = ($signed(a) < $signed(b)); end
         OP_BEQZ: begin is_branch = 1'b1; cond = (a == '0); end
         OP_BNEZ: begin is_branch = 1'b1; cond = (a != '0); end
         OP_BGEZ: begin is_branch = 1'b1; cond = !a[31]; end
         OP_BLEZ: begin is_branch = 1'b1; cond = (a == '0) || a[31]; end
         OP_BGTZ: begin is_branch = 1'b1; cond = (a != '0) && !a[31]; end
         OP_BLTZ: begin is_branch = 1'b1; cond = a[31]; end
         OP_LINK: o.target_address = r.next_pc;
         OP_MOVE: o.result = a;
         OP_MFHI: o.result = hi_word;
         OP_MFLO: o.result = lo_word;
         default: ;
      endcase
      if (is_branch) begin
         o.branch_taken = cond;
         o.target_address = cond ? r.immediate : r.next_pc;
      end
      return o;
   endfunction

   task automatic add_request(logic [OP_WIDTH-1:0] op, word_type a, word_type b, logic wr);
      alu_req_type r;
      r.operation = op;
      r.operand_a = a;
      r.operand_b = b;
      r.immediate = word_type'($urandom());
      r.next_pc = word_type'($urandom());
      r.write_to_register = wr;
      pending_reqs.push_back(r);
   endtask

   // Driver: advance to the next pending request once the current one is taken.
   always @(posedge clock) begin : drive_requests
      alu_req_type next_req;
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (pending_reqs.size() > 0 && !take_break(sent_reqs)) begin
            next_req = pending_reqs.pop_front();
            sent_reqs++;
            req_valid <= 1'b1;
            req_operation <= next_req.operation;
            req_operand_a <= next_req.operand_a;
            req_operand_b <= next_req.operand_b;
            req_immediate <= next_req.immediate;
            req_next_pc <= next_req.next_pc;
            req_write_to_register <= next_req.write_to_register;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // Monitor: predict on each accepted request, then check each accepted response.
   always @(posedge clock) begin : check_responses
      alu_rsp_type want, got;
      bit          moved;
      if (reset) begin
         rsp_ready <= 1'b0;
         hi_word = '0;
         lo_word = '0;
         quiet_cycles = 0;
      end else begin
         moved = 1'b0;
         rsp_ready <= !take_break(accepted_rsps);
         if (req_valid && req_ready) begin
            moved = 1'b1;
            expected_rsps.push_back(predict_execute({req_operation, req_operand_a, req_operand_b,
                                                     req_immediate, req_next_pc,
                                                     req_write_to_register}));
         end
         if (rsp_valid && rsp_ready) begin
            moved = 1'b1;
            accepted_rsps++;
            got = {rsp_result, rsp_target_address, rsp_branch_taken, rsp_divide_by_zero};
            if (expected_rsps.size() == 0) begin
               mismatches++;
               if (mismatches <= MAX_SHOWN)
                  $display("unexpected response: result %h target %h taken %b dz %b",
                           got.result, got.target_address, got.branch_taken,
                           got.divide_by_zero);
            end else begin
               want = expected_rsps.pop_front();
               if (want.result !== got.result || want.target_address !== got.target_address ||
                   want.branch_taken !== got.branch_taken ||
                   want.divide_by_zero !== got.divide_by_zero) begin
                  mismatches++;
                  if (mismatches <= MAX_SHOWN)
                     $display({"response %0d: expected result %h target %h taken %b dz %b,",
                               " got result %h target %h taken %b dz %b"},
                              accepted_rsps, want.result, want.target_address,
                              want.branch_taken, want.divide_by_zero, got.result,
                              got.target_address, got.branch_taken, got.divide_by_zero);
               end
            end
         end
         quiet_cycles = moved ? 0 : quiet_cycles + 1;
      end
   end

   initial begin : run_test
      int       items;
      int       kind;
      word_type x;
      bit       timed_out;

      add_request(OP_ADD, 32'hffff_ffff, 32'h0000_0001, 1'b0);
      add_request(OP_SUBU, 32'h0000_0000, 32'h0000_0001, 1'b1);
      add_request(OP_MUL, 32'h8000_0000, 32'h8000_0000, 1'b0);
      add_request(OP_MFHI, '0, '0, 1'b0);
      add_request(OP_MFLO, '0, '0, 1'b0);
      add_request(OP_MULU, 32'hffff_ffff, 32'hffff_ffff, 1'b0);
      add_request(OP_MFHI, '0, '0, 1'b1);
      add_request(OP_MUL, 32'hffff_ffff, 32'h7fff_ffff, 1'b0);
      add_request(OP_MFHI, '0, '0, 1'b0);
      add_request(OP_DIV, 32'h8000_0000, 32'hffff_ffff, 1'b0);
      add_request(OP_MFHI, '0, '0, 1'b0);
      add_request(OP_MFLO, '0, '0, 1'b0);
      add_request(OP_DIVU, 32'h0000_1234, 32'h0000_0000, 1'b0);
      add_request(OP_MFHI, '0, '0, 1'b0);
      add_request(OP_MFLO, '0, '0, 1'b0);
      add_request(OP_DIV, 32'hffff_fff9, 32'h0000_0000, 1'b1);
      add_request(OP_MULU, 32'hffff_ffff, 32'hffff_ffff, 1'b1);
      add_request(OP_REM, 32'hffff_fff9, 32'h0000_0002, 1'b0);
      add_request(OP_REMU, 32'h0000_0005, 32'h0000_0000, 1'b0);
      add_request(OP_NEG, 32'h8000_0000, '0, 1'b0);
      add_request(OP_NEGU, 32'h0000_0001, '0, 1'b0);
      add_request(OP_SLT, 32'h8000_0000, 32'h7fff_ffff, 1'b0);
      add_request(OP_BLEZ, 32'h0000_0000, '0, 1'b0);
      add_request(OP_BGTZ, 32'h8000_0000, '0, 1'b0);
      add_request(OP_STORE, 32'hffff_ffff, 32'h8000_0000, 1'b0);
      add_request(OP_WIDTH'(LAST_OP_CODE), 32'hffff_ffff, 32'hffff_ffff, 1'b1);

      items = 0;
      while (items < RANDOM_ITEMS) begin
         kind = $urandom_range(0, 99);
         if (kind < 20) begin
            if ($urandom_range(0, 1))
               add_request($urandom_range(0, 1) ? OP_MUL : OP_MULU, pick_operand(),
                           pick_operand(), 1'b0);
            else
               add_request($urandom_range(0, 1) ? OP_DIV : OP_DIVU, pick_operand(),
                           pick_operand(), 1'b0);
            if ($urandom_range(0, 1)) begin
               add_request(OP_MFHI, word_type'($urandom()), word_type'($urandom()),
                           1'($urandom()));
               add_request(OP_MFLO, word_type'($urandom()), word_type'($urandom()),
                           1'($urandom()));
            end else begin
               add_request(OP_MFLO, word_type'($urandom()), word_type'($urandom()),
                           1'($urandom()));
               add_request(OP_MFHI, word_type'($urandom()), word_type'($urandom()),
                           1'($urandom()));
            end
            items += 3;
         end else if (kind < 26) begin
            add_request(OP_WIDTH'($urandom_range(FIRST_UNKNOWN_OP, LAST_OP_CODE)),
                        word_type'($urandom()), word_type'($urandom()), 1'($urandom()));
            items++;
         end else begin
            x = pick_operand();
            add_request(OP_WIDTH'($urandom_range(0, int'(OP_NOP))), x,
                        ($urandom_range(0, 9) == 0) ? x : pick_operand(), 1'($urandom()));
            items++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      timed_out = 1'b0;
      while ((pending_reqs.size() > 0 || req_valid || expected_rsps.size() > 0) &&
             !timed_out) begin
         @(posedge clock);
         timed_out = (quiet_cycles >= STALL_LIMIT);
      end
      if (!timed_out) repeat (DRAIN_CYCLES) @(posedge clock);

      if (!timed_out && mismatches == 0 && expected_rsps.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
